[design/siq_pkg.sv]
// shared types and codes for the sorted insert queue
package siq_pkg;

  localparam int DataW = 8;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_INSERT  = 2'd0;
  localparam cmd_t CMD_APPEND  = 2'd1;
  localparam cmd_t CMD_DEQUEUE = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_DONE       = 2'd0;
  localparam status_t ST_REJ_FULL   = 2'd1;
  localparam status_t ST_REJ_EMPTY  = 2'd2;

  typedef logic signed [DataW-1:0] value_t;

  // operation broadcast to every cell, at most one bit set
  typedef struct packed {
    logic ins;
    logic app;
    logic deq;
  } cell_ctrl_t;

endpackage

[design/sorted_insert_queue_core.sv]
// top level of the sorted insert queue: row of cells, count and result register
//
//  channel | dir | handshake                 | payload
//  s_axis  | in  | s_tvalid / s_tready       | s_tdata: command, data
//  m_axis  | out | m_tvalid / m_tready       | m_tdata: head_value, is_empty,
//          |     |                           |   is_full, entry_count, status
//
// one word per cycle unless stalled: every cell compares against the new byte
// and shifts in the same clock, the insert point found by a pass chain along
// the row. a taken word's result is in the output register in the next cycle.
// s_tready stays high while the output register is empty or being drained.
// rst clears the count and the output valid; cell contents are not cleared.
module sorted_insert_queue_core
  import siq_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [1:0] command, [9:2] data, [15:10] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [7:0] head_value, [8] is_empty, [9] is_full,
                                 // [13:10] entry_count, [15:14] status
);

  localparam int CW  = $clog2(DEPTH + 1);
  localparam int CXW = (CW > 4) ? CW : 4;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CXW-1:0] count_ext;

  cmd_t       command;
  value_t     data;
  logic       in_acc;
  logic       full;
  logic       empty;
  status_t    status;
  cell_ctrl_t ctrl;

  value_t            cell_value [DEPTH];
  value_t            cell_next  [DEPTH];
  logic [DEPTH:0]    pass;
  logic [DEPTH-1:0]  occ;

  value_t head_next;

  assign command  = s_tdata[1:0];
  assign data     = s_tdata[9:2];
  assign s_tready = !m_tvalid || m_tready;
  assign in_acc   = s_tvalid && s_tready;
  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);

  always_comb begin
    ctrl       = '0;
    status     = ST_DONE;
    count_next = count;
    if (in_acc) begin
      unique case (command)
        CMD_INSERT, CMD_APPEND: begin
          if (full) begin
            status = ST_REJ_FULL;
          end else begin
            ctrl.ins   = (command == CMD_INSERT);
            ctrl.app   = (command == CMD_APPEND);
            count_next = count + CW'(1);
          end
        end
        CMD_DEQUEUE: begin
          if (empty) begin
            status = ST_REJ_EMPTY;
          end else begin
            ctrl.deq   = 1'b1;
            count_next = count - CW'(1);
          end
        end
        default: begin
          status = ST_DONE;
        end
      endcase
    end
  end

  assign pass[0] = 1'b1;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ[i] = (CW'(i) < count);

    siq_cell u_cell (
      .clk           (clk),
      .ctrl          (ctrl),
      .new_value     (data),
      .left_value    ((i == 0) ? data : cell_value[(i == 0) ? 0 : i - 1]),
      .right_value   (cell_value[(i == DEPTH - 1) ? i : i + 1]),
      .left_occupied ((i == 0) ? 1'b1 : occ[(i == 0) ? 0 : i - 1]),
      .occupied      (occ[i]),
      .pass_in       (pass[i]),
      .pass_out      (pass[i+1]),
      .value         (cell_value[i]),
      .value_next    (cell_next[i])
    );
  end

  assign head_next = (count_next != '0) ? cell_next[0] : '0;
  assign count_ext = CXW'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (in_acc) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (in_acc) begin
      m_tdata <= {status, count_ext[3:0], (count_next == CW'(DEPTH)),
                  (count_next == '0), head_next};
    end
  end

  // a rejected insert or append leaves the count untouched
  assert property (@(posedge clk) disable iff (rst)
    in_acc && full && (command == CMD_INSERT || command == CMD_APPEND)
      |=> count == $past(count))
    else $error("count changed on rejected insert");

  assert property (@(posedge clk) disable iff (rst)
    in_acc && empty && command == CMD_DEQUEUE
      |=> m_tvalid && m_tdata[15:14] == ST_REJ_EMPTY)
    else $error("dequeue on empty not reported");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[8] |-> m_tdata[7:0] == 8'd0 && !m_tdata[9])
    else $error("empty result with head or full flag set");

  assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("count above depth");

endmodule

[design/siq_cell.sv]
// one storage cell of the queue: keep, take new word, or shift from a neighbor
module siq_cell
  import siq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  value_t     new_value,
  input  value_t     left_value,
  input  value_t     right_value,
  input  logic       left_occupied,
  input  logic       occupied,
  input  logic       pass_in,
  output logic       pass_out,
  output value_t     value,
  output value_t     value_next
);

  logic lt;

  // an empty cell never passes, so the insert lands at the tail at the latest
  assign lt       = occupied && (value < new_value);
  assign pass_out = pass_in && lt;

  always_comb begin
    value_next = value;
    if (ctrl.ins) begin
      if (!pass_in) begin
        value_next = left_value;
      end else if (!lt) begin
        value_next = new_value;
      end
    end else if (ctrl.app) begin
      if (left_occupied && !occupied) begin
        value_next = new_value;
      end
    end else if (ctrl.deq) begin
      value_next = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule
